FILE: hdl/nfa_pkg.sv
package nfa_pkg;

    localparam int ADDR_W       = 16;
    localparam int SIZE_W       = 17;
    localparam int BYTES_W      = 20;
    localparam int HEAP_UNITS   = 65536;
    localparam int UNIT_SHIFT   = 4;                    // 16-byte units
    localparam int A_GUARD_W    = 18;
    localparam int I_GUARD_W    = 17;
    localparam int A_GUARD_MAX  = 2 * HEAP_UNITS + 4;
    localparam int I_GUARD_MAX  = HEAP_UNITS;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_A_FIRST,
        ST_A_CHECK,
        ST_A_CARVE,
        ST_I_START,
        ST_I_WALK,
        ST_M_HB,
        ST_M_NEXT,
        ST_M_PREV,
        ST_R_READ,
        ST_R_RESUME,
        ST_DONE
    } nfa_state_t;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_ALLOC_LOAD,
        CMD_FREE_LOAD,
        CMD_DONE0,
        CMD_OOM,
        CMD_A_FIRST,
        CMD_A_EXACT,
        CMD_A_CARVE1,
        CMD_A_CARVE2,
        CMD_A_GROW,
        CMD_A_NEXT,
        CMD_A_RESUME,
        CMD_I_START,
        CMD_I_BREAK,
        CMD_I_NEXT,
        CMD_M_HB,
        CMD_M_NEXT,
        CMD_M_PREV,
        CMD_R_READ,
        CMD_EMIT
    } nfa_cmd_t;

    typedef struct packed {
        logic fit_exact;
        logic fit_carve;
        logic at_rover;
        logic grow_fail;
        logic a_guard_last;
        logic ins_break;
        logic i_guard_last;
        logic addr_zero;
        logic out_busy;
    } nfa_status_t;

endpackage

FILE: hdl/nfa_ctrl.sv
module nfa_ctrl
    import nfa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_action,
    output logic        s_ready,
    input  nfa_status_t status,
    output nfa_cmd_t    cmd
);

    nfa_state_t state_reg, state_next;
    logic       from_alloc_reg, from_alloc_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            from_alloc_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            from_alloc_reg <= from_alloc_next;
        end
    end

    // next state
    always_comb begin
        state_next      = state_reg;
        from_alloc_next = from_alloc_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_action == ACT_ALLOC) begin
                        state_next = ST_A_FIRST;
                    end else if (status.addr_zero) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next      = ST_I_START;
                        from_alloc_next = 1'b0;
                    end
                end
            end
            ST_A_FIRST:  state_next = ST_A_CHECK;
            ST_A_CHECK: begin
                if (status.fit_exact) begin
                    state_next = ST_DONE;
                end else if (status.fit_carve) begin
                    state_next = ST_A_CARVE;
                end else if (status.at_rover) begin
                    if (status.grow_fail) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next      = ST_I_START;
                        from_alloc_next = 1'b1;
                    end
                end else if (status.a_guard_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_A_CARVE:  state_next = ST_DONE;
            ST_I_START:  state_next = ST_I_WALK;
            ST_I_WALK: begin
                if (status.ins_break) begin
                    state_next = ST_M_HB;
                end else if (status.i_guard_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_M_HB:     state_next = ST_M_NEXT;
            ST_M_NEXT:   state_next = ST_M_PREV;
            ST_M_PREV:   state_next = from_alloc_reg ? ST_R_READ : ST_DONE;
            ST_R_READ:   state_next = ST_R_RESUME;
            ST_R_RESUME: state_next = status.a_guard_last ? ST_DONE : ST_A_CHECK;
            ST_DONE: begin
                if (!status.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd     = CMD_NONE;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_action == ACT_ALLOC) begin
                        cmd = CMD_ALLOC_LOAD;
                    end else if (status.addr_zero) begin
                        cmd = CMD_DONE0;
                    end else begin
                        cmd = CMD_FREE_LOAD;
                    end
                end
            end
            ST_A_FIRST:  cmd = CMD_A_FIRST;
            ST_A_CHECK: begin
                if (status.fit_exact) begin
                    cmd = CMD_A_EXACT;
                end else if (status.fit_carve) begin
                    cmd = CMD_A_CARVE1;
                end else if (status.at_rover) begin
                    cmd = status.grow_fail ? CMD_OOM : CMD_A_GROW;
                end else if (status.a_guard_last) begin
                    cmd = CMD_OOM;
                end else begin
                    cmd = CMD_A_NEXT;
                end
            end
            ST_A_CARVE:  cmd = CMD_A_CARVE2;
            ST_I_START:  cmd = CMD_I_START;
            ST_I_WALK: begin
                if (status.ins_break) begin
                    cmd = CMD_I_BREAK;
                end else if (status.i_guard_last) begin
                    cmd = from_alloc_reg ? CMD_OOM : CMD_DONE0;
                end else begin
                    cmd = CMD_I_NEXT;
                end
            end
            ST_M_HB:     cmd = CMD_M_HB;
            ST_M_NEXT:   cmd = CMD_M_NEXT;
            ST_M_PREV:   cmd = CMD_M_PREV;
            ST_R_READ:   cmd = CMD_R_READ;
            ST_R_RESUME: cmd = status.a_guard_last ? CMD_OOM : CMD_A_RESUME;
            ST_DONE: begin
                if (!status.out_busy) begin
                    cmd = CMD_EMIT;
                end
            end
            default:     cmd = CMD_NONE;
        endcase
    end

endmodule

FILE: hdl/nfa_datapath.sv
module nfa_datapath
    import nfa_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  nfa_cmd_t            cmd,
    output nfa_status_t         status,
    input  logic [BYTES_W-1:0]  s_request_bytes,
    input  logic [ADDR_W-1:0]   s_block_address,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [ADDR_W-1:0]   m_payload_address,
    output logic                m_status
);

    // header store, split so either half can be written alone
    logic [ADDR_W-1:0] next_mem [HEAP_UNITS];
    logic [SIZE_W-1:0] size_mem [HEAP_UNITS];

    logic [ADDR_W-1:0]    rd_addr;
    logic [ADDR_W-1:0]    wr_addr;
    logic                 wr_next_en, wr_size_en;
    logic [ADDR_W-1:0]    wr_next;
    logic [SIZE_W-1:0]    wr_size;
    logic [ADDR_W-1:0]    mem_next_reg;
    logic [SIZE_W-1:0]    mem_size_reg;
    logic                 rd_zero_reg;
    logic                 u0n_valid_reg, u0s_valid_reg;
    logic [ADDR_W-1:0]    rd_next;
    logic [SIZE_W-1:0]    rd_size;

    logic [ADDR_W-1:0]    rover_reg, rover_next;
    logic [SIZE_W-1:0]    bump_reg, bump_next;
    logic                 m_valid_reg, m_valid_next;

    logic [SIZE_W-1:0]    need_reg;
    logic [ADDR_W-1:0]    prev_reg, p_reg, q_reg, ip_reg, n_reg, hb_reg, hb_next_reg;
    logic [SIZE_W-1:0]    hb_size_reg;
    logic [A_GUARD_W-1:0] aguard_reg;
    logic [I_GUARD_W-1:0] iguard_reg;
    logic [ADDR_W-1:0]    res_addr_reg, out_addr_reg;
    logic                 res_oom_reg, out_oom_reg;

    logic [BYTES_W:0]     bytes_round;
    logic [SIZE_W-1:0]    need_calc;
    logic [SIZE_W-1:0]    carve_size;
    logic [ADDR_W-1:0]    carve_addr;
    logic                 hb_adj_n, p_adj_hb;
    logic [SIZE_W-1:0]    merged_size;

    assign rd_next = (rd_zero_reg && !u0n_valid_reg) ? '0 : mem_next_reg;
    assign rd_size = (rd_zero_reg && !u0s_valid_reg) ? '0 : mem_size_reg;

    assign bytes_round = {1'b0, s_request_bytes} + (BYTES_W+1)'((1 << UNIT_SHIFT) - 1);
    assign need_calc   = SIZE_W'(bytes_round >> UNIT_SHIFT) + SIZE_W'(1);
    assign carve_size  = rd_size - need_reg;
    assign carve_addr  = p_reg + carve_size[ADDR_W-1:0];
    assign hb_adj_n    = ({2'b0, hb_reg} + {1'b0, hb_size_reg}) == {2'b0, n_reg};
    assign p_adj_hb    = ({2'b0, ip_reg} + {1'b0, rd_size}) == {2'b0, hb_reg};
    assign merged_size = hb_size_reg + rd_size;

    always_comb begin
        status.fit_exact    = (rd_size == need_reg);
        status.fit_carve    = (rd_size > need_reg);
        status.at_rover     = (p_reg == rover_reg);
        status.grow_fail    = ({1'b0, bump_reg} + {1'b0, need_reg}) > (SIZE_W+1)'(HEAP_UNITS);
        status.a_guard_last = aguard_reg >= A_GUARD_W'(A_GUARD_MAX);
        status.ins_break    = (hb_reg > ip_reg && hb_reg < rd_next)
                           || (ip_reg >= rd_next && (hb_reg > ip_reg || hb_reg < rd_next));
        status.i_guard_last = iguard_reg >= I_GUARD_W'(I_GUARD_MAX);
        status.addr_zero    = (s_block_address == '0);
        status.out_busy     = m_valid_reg && !m_ready;
    end

    // memory port control
    always_comb begin
        rd_addr    = rover_reg;
        wr_addr    = p_reg;
        wr_next_en = 1'b0;
        wr_size_en = 1'b0;
        wr_next    = rd_next;
        wr_size    = rd_size;
        case (cmd)
            CMD_A_FIRST, CMD_A_NEXT, CMD_A_RESUME, CMD_I_NEXT: rd_addr = rd_next;
            CMD_I_BREAK: rd_addr = hb_reg;
            CMD_M_HB:    rd_addr = n_reg;
            CMD_M_NEXT: begin
                rd_addr    = ip_reg;
                wr_addr    = hb_reg;
                wr_next_en = 1'b1;
                if (hb_adj_n) begin
                    wr_size_en = 1'b1;
                    wr_size    = merged_size;
                    wr_next    = rd_next;
                end else begin
                    wr_next    = n_reg;
                end
            end
            CMD_M_PREV: begin
                wr_addr    = ip_reg;
                wr_next_en = 1'b1;
                if (p_adj_hb) begin
                    wr_size_en = 1'b1;
                    wr_size    = rd_size + hb_size_reg;
                    wr_next    = hb_next_reg;
                end else begin
                    wr_next    = hb_reg;
                end
            end
            CMD_A_EXACT: begin
                wr_addr    = prev_reg;
                wr_next_en = 1'b1;
                wr_next    = rd_next;
            end
            CMD_A_CARVE1: begin
                wr_addr    = p_reg;
                wr_size_en = 1'b1;
                wr_size    = carve_size;
            end
            CMD_A_CARVE2: begin
                wr_addr    = q_reg;
                wr_size_en = 1'b1;
                wr_size    = need_reg;
            end
            CMD_A_GROW: begin
                wr_addr    = bump_reg[ADDR_W-1:0];
                wr_size_en = 1'b1;
                wr_size    = need_reg;
            end
            default: rd_addr = rover_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_next_en) begin
            next_mem[wr_addr] <= wr_next;
        end
        if (wr_size_en) begin
            size_mem[wr_addr] <= wr_size;
        end
        mem_next_reg <= next_mem[rd_addr];
        mem_size_reg <= size_mem[rd_addr];
        rd_zero_reg  <= (rd_addr == '0);
    end

    always_comb begin
        rover_next   = rover_reg;
        bump_next    = bump_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (cmd)
            CMD_A_EXACT, CMD_A_CARVE1: rover_next = prev_reg;
            CMD_M_PREV:                rover_next = ip_reg;
            CMD_A_GROW:                bump_next  = bump_reg + need_reg;
            CMD_EMIT:                  m_valid_next = 1'b1;
            default:                   rover_next = rover_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rover_reg     <= '0;
            bump_reg      <= SIZE_W'(1);
            m_valid_reg   <= 1'b0;
            u0n_valid_reg <= 1'b0;
            u0s_valid_reg <= 1'b0;
        end else begin
            rover_reg   <= rover_next;
            bump_reg    <= bump_next;
            m_valid_reg <= m_valid_next;
            if (wr_next_en && wr_addr == '0) begin
                u0n_valid_reg <= 1'b1;
            end
            if (wr_size_en && wr_addr == '0) begin
                u0s_valid_reg <= 1'b1;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        case (cmd)
            CMD_ALLOC_LOAD: begin
                need_reg   <= need_calc;
                prev_reg   <= rover_reg;
                aguard_reg <= '0;
            end
            CMD_FREE_LOAD: begin
                hb_reg       <= s_block_address - ADDR_W'(1);
                res_addr_reg <= '0;
                res_oom_reg  <= 1'b0;
            end
            CMD_DONE0: begin
                res_addr_reg <= '0;
                res_oom_reg  <= 1'b0;
            end
            CMD_OOM: begin
                res_addr_reg <= '0;
                res_oom_reg  <= 1'b1;
            end
            CMD_A_FIRST: p_reg <= rd_next;
            CMD_A_EXACT: begin
                res_addr_reg <= p_reg + ADDR_W'(1);
                res_oom_reg  <= 1'b0;
            end
            CMD_A_CARVE1: q_reg <= carve_addr;
            CMD_A_CARVE2: begin
                res_addr_reg <= q_reg + ADDR_W'(1);
                res_oom_reg  <= 1'b0;
            end
            CMD_A_GROW: hb_reg <= bump_reg[ADDR_W-1:0];
            CMD_A_NEXT: begin
                aguard_reg <= aguard_reg + A_GUARD_W'(1);
                prev_reg   <= p_reg;
                p_reg      <= rd_next;
            end
            CMD_A_RESUME: begin
                aguard_reg <= aguard_reg + A_GUARD_W'(1);
                prev_reg   <= rover_reg;
                p_reg      <= rd_next;
            end
            CMD_I_START: begin
                ip_reg     <= rover_reg;
                iguard_reg <= '0;
            end
            CMD_I_NEXT: begin
                iguard_reg <= iguard_reg + I_GUARD_W'(1);
                ip_reg     <= rd_next;
            end
            CMD_I_BREAK: n_reg <= rd_next;
            CMD_M_HB:    hb_size_reg <= rd_size;
            CMD_M_NEXT: begin
                if (hb_adj_n) begin
                    hb_size_reg <= merged_size;
                    hb_next_reg <= rd_next;
                end else begin
                    hb_next_reg <= n_reg;
                end
            end
            CMD_EMIT: begin
                out_addr_reg <= res_addr_reg;
                out_oom_reg  <= res_oom_reg;
            end
            default: begin
                p_reg <= p_reg;
            end
        endcase
    end

    assign m_valid           = m_valid_reg;
    assign m_payload_address = out_addr_reg;
    assign m_status          = out_oom_reg;

endmodule

FILE: hdl/next_fit_free_list_allocator_core.sv
// Channel   Handshake          Payload
// s_        s_valid/s_ready    s_action, s_request_bytes, s_block_address
// m_        m_valid/m_ready    m_payload_address, m_status
//
// One request at a time. An allocate walks the free list, reading one header per
// cycle; growing the heap adds an insert walk and the merge steps. A free takes
// the insert walk and the merge steps.
// The header memory has one read port and one write port.
// Reset is synchronous, active low; it needs no clearing pass.
// A result waits in the output register while the next request is taken in.
module next_fit_free_list_allocator_core
    import nfa_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_action,
    input  logic [BYTES_W-1:0] s_request_bytes,
    input  logic [ADDR_W-1:0]  s_block_address,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [ADDR_W-1:0]  m_payload_address,
    output logic               m_status
);

    nfa_cmd_t    cmd;
    nfa_status_t status;

    // sequencer: walk control, insert/merge steps, result hand-off
    nfa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_action),
        .s_ready  (s_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // header store, rover, bump pointer and the output register
    nfa_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .s_request_bytes   (s_request_bytes),
        .s_block_address   (s_block_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_payload_address (m_payload_address),
        .m_status          (m_status)
    );

endmodule

FILE: verif/tb_next_fit_free_list_allocator_core.sv
module tb_next_fit_free_list_allocator_core;
    import nfa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Heap tracker: mirrors the header store, start pointer and bump pointer,
    // predicts the reply to every accepted request and checks replies in order.
    class heap_scoreboard;
        int unsigned link_of [HEAP_UNITS];
        int unsigned units_of[HEAP_UNITS];
        int unsigned start_ptr;
        int unsigned grow_ptr;
        logic [ADDR_W-1:0] want_addr[$];
        logic              want_oom[$];
        int unsigned       live_blocks[$];
        int                errors;

        function new();
            start_ptr = 0;
            grow_ptr  = 1;
            errors    = 0;
        endfunction

        function int unsigned wrap(int unsigned a);
            return a % HEAP_UNITS;
        endfunction

        // Link a block into the address-ordered ring, merging with neighbours.
        function bit link_block(int unsigned hb);
            int unsigned p;
            int unsigned n;
            int unsigned guard;
            p = start_ptr;
            guard = 0;
            forever begin
                n = wrap(link_of[p]);
                if (hb > p && hb < n) break;
                if (p >= n && (hb > p || hb < n)) break;
                guard++;
                if (guard > HEAP_UNITS) return 0;
                p = n;
            end
            if (hb + units_of[hb] == n) begin
                units_of[hb] += units_of[n];
                link_of[hb] = wrap(link_of[n]);
            end else begin
                link_of[hb] = n;
            end
            if (p + units_of[p] == hb) begin
                units_of[p] += units_of[hb];
                link_of[p] = wrap(link_of[hb]);
            end else begin
                link_of[p] = hb;
            end
            start_ptr = p;
            return 1;
        endfunction

        function int unsigned carve(int unsigned nbytes, output bit oom);
            int unsigned need;
            int unsigned prev;
            int unsigned p;
            int unsigned s;
            int unsigned b;
            int unsigned guard;
            need  = (nbytes + (1 << UNIT_SHIFT) - 1) / (1 << UNIT_SHIFT) + 1;
            prev  = start_ptr;
            p     = wrap(link_of[prev]);
            guard = 0;
            oom   = 0;
            forever begin
                s = units_of[p];
                if (s >= need) begin
                    if (s == need) begin
                        link_of[prev] = wrap(link_of[p]);
                    end else begin
                        s -= need;
                        units_of[p] = s;
                        p = wrap(p + s);
                        units_of[p] = need;
                    end
                    start_ptr = prev;
                    return p + 1;
                end
                if (p == start_ptr) begin
                    b = grow_ptr;
                    if (b + need > HEAP_UNITS) begin
                        oom = 1;
                        return 0;
                    end
                    units_of[b] = need;
                    grow_ptr = b + need;
                    if (!link_block(b)) begin
                        oom = 1;
                        return 0;
                    end
                    p = start_ptr;
                end
                guard++;
                if (guard > A_GUARD_MAX) begin
                    oom = 1;
                    return 0;
                end
                prev = p;
                p = wrap(link_of[p]);
            end
        endfunction

        function void note_request(logic act, logic [BYTES_W-1:0] nbytes,
                                   logic [ADDR_W-1:0] addr);
            int unsigned pa;
            bit          oom;
            pa  = 0;
            oom = 0;
            if (act == ACT_ALLOC) begin
                pa = carve(nbytes, oom);
                if (!oom) live_blocks.push_back(pa);
            end else if (addr != 0) begin
                void'(link_block(addr - 1));
                foreach (live_blocks[i]) begin
                    if (live_blocks[i] == addr) begin
                        live_blocks.delete(i);
                        break;
                    end
                end
            end
            want_addr.push_back(pa[ADDR_W-1:0]);
            want_oom.push_back(oom);
        endfunction

        function void check_reply(logic [ADDR_W-1:0] pa, logic st);
            logic [ADDR_W-1:0] ea;
            logic              eo;
            if (want_addr.size() == 0) begin
                $display("%0t: unexpected reply addr=%0d status=%0d", $time, pa, st);
                errors++;
                return;
            end
            ea = want_addr.pop_front();
            eo = want_oom.pop_front();
            if (pa !== ea) begin
                $display("%0t: payload_address expected %0d actual %0d", $time, ea, pa);
                errors++;
            end
            if (st !== eo) begin
                $display("%0t: status expected %0d actual %0d", $time, eo, st);
                errors++;
            end
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_action = ACT_ALLOC;
    logic [BYTES_W-1:0] s_request_bytes = '0;
    logic [ADDR_W-1:0]  s_block_address = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [ADDR_W-1:0]  m_payload_address;
    logic               m_status;

    heap_scoreboard sb = new();

    // Idle percentages for the current phase; hold_off_req asks the reply side
    // for one long stall so that the block backs up into its request port.
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_off_req = 0;
    bit  reset_done = 0;

    always #1 aclk = ~aclk;

    next_fit_free_list_allocator_core uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_request_bytes   (s_request_bytes),
        .s_block_address   (s_block_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_payload_address (m_payload_address),
        .m_status          (m_status)
    );

    // Offer one request and hold it until taken; the prediction is made at the
    // very edge where the handshake completes.
    task automatic offer(logic act, logic [BYTES_W-1:0] nbytes, logic [ADDR_W-1:0] addr);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_action        <= act;
        s_request_bytes <= nbytes;
        s_block_address <= addr;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(act, nbytes, addr);
    endtask

    // Free a live block picked at random; fall back to an allocate when none.
    task automatic free_some();
        int k;
        if (sb.live_blocks.size() == 0) begin
            offer(ACT_ALLOC, BYTES_W'($urandom_range(0, 200)), ADDR_W'($urandom));
        end else begin
            k = $urandom_range(sb.live_blocks.size() - 1);
            offer(ACT_FREE, BYTES_W'($urandom), ADDR_W'(sb.live_blocks[k]));
        end
    endtask

    task automatic random_request();
        int r;
        int sz;
        r = $urandom_range(99);
        if (r < 42) begin
            free_some();
        end else if (r < 44) begin
            // address zero must be ignored
            offer(ACT_FREE, BYTES_W'($urandom), '0);
        end else begin
            sz = $urandom_range(99);
            if (sz < 75)      sz = $urandom_range(0, 400);
            else if (sz < 95) sz = $urandom_range(0, 8000);
            else if (sz < 98) sz = $urandom_range(0, 120000);
            else              sz = $urandom_range(0, (1 << BYTES_W) - 1);
            offer(ACT_ALLOC, BYTES_W'(sz), ADDR_W'($urandom));
        end
    endtask

    // Reply side: check every accepted reply, then stall at random or, on
    // request, hold off for a long counted stretch.
    initial begin
        int hold_cnt;
        hold_cnt = 0;
        wait (reset_done);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) sb.check_reply(m_payload_address, m_status);
            if (hold_off_req) begin
                hold_off_req = 0;
                hold_cnt = 400;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        int phase_idle[4];
        int phase_stall[4];
        int wait_cnt;
        phase_idle  = '{0, 70, 0, 30};
        phase_stall = '{0, 0, 70, 30};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        reset_done = 1;
        @(posedge aclk);

        // Directed: size extremes, rounding edges, oversize, big grow and
        // merging frees, ignored free of address zero.
        offer(ACT_ALLOC, '0, '0);
        offer(ACT_ALLOC, BYTES_W'(1), '1);
        offer(ACT_ALLOC, BYTES_W'(16), '0);
        offer(ACT_ALLOC, BYTES_W'(17), '1);
        offer(ACT_ALLOC, '1, '0);
        offer(ACT_ALLOC, BYTES_W'(600000), '0);
        offer(ACT_ALLOC, BYTES_W'(600000), '0);
        offer(ACT_FREE, '0, '0);
        offer(ACT_FREE, '1, ADDR_W'(sb.live_blocks[1]));
        offer(ACT_FREE, '0, ADDR_W'(sb.live_blocks[1]));
        offer(ACT_ALLOC, BYTES_W'(40), '0);
        offer(ACT_ALLOC, BYTES_W'(15), '0);
        offer(ACT_FREE, '0, ADDR_W'(sb.live_blocks[0]));
        offer(ACT_FREE, '0, ADDR_W'(sb.live_blocks[sb.live_blocks.size() - 1]));
        offer(ACT_ALLOC, BYTES_W'(500000), '0);
        while (sb.live_blocks.size() > 0) free_some();

        // Random phases; the first stalled phase also gets the long hold-off.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = phase_idle[ph];
            recv_stall_pct = phase_stall[ph];
            if (ph == 2) hold_off_req = 1;
            repeat (300) random_request();
        end
        s_valid <= 1'b0;

        // Drain and allow for any trailing activity before the verdict.
        wait_cnt = 0;
        while (sb.want_addr.size() != 0 && wait_cnt < 200000) begin
            @(posedge aclk);
            wait_cnt++;
        end
        repeat (200) @(posedge aclk);
        if (sb.want_addr.size() != 0) begin
            $display("%0t: %0d replies never arrived", $time, sb.want_addr.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog: stop a hung run.
    initial begin
        #40ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
